>>> src/ecpi_pkg.sv
// ----------------------------------------------------------------------------
// ecpi_pkg
// Shared widths and the beat record that travels down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ecpi_pkg;

    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 4 * CHAN_W;
    localparam int IDX_W   = 8;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic [COLOR_W-1:0] color;
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic               is_new;
    } beat_t;

endpackage

`default_nettype wire

>>> src/ecpi_pixel_if.sv
// ----------------------------------------------------------------------------
// ecpi_pixel_if
// Pixel channel: valid/ready handshake with the four bytes and start marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecpi_pixel_if;

    logic       valid;
    logic       ready;
    logic       first_pixel;
    logic [7:0] channel_0;
    logic [7:0] channel_1;
    logic [7:0] channel_2;
    logic [7:0] channel_3;

    modport source (
        output valid, first_pixel, channel_0, channel_1, channel_2, channel_3,
        input  ready
    );

    modport sink (
        input  valid, first_pixel, channel_0, channel_1, channel_2, channel_3,
        output ready
    );

endinterface

`default_nettype wire

>>> src/ecpi_result_if.sv
// ----------------------------------------------------------------------------
// ecpi_result_if
// Result channel: valid/ready handshake with palette index and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecpi_result_if;

    logic       valid;
    logic       ready;
    logic [7:0] color_index;
    logic       is_new_entry;
    logic       overflowed;

    modport source (
        output valid, color_index, is_new_entry, overflowed,
        input  ready
    );

    modport sink (
        input  valid, color_index, is_new_entry, overflowed,
        output ready
    );

endinterface

`default_nettype wire

>>> src/ecpi_cell.sv
// ----------------------------------------------------------------------------
// ecpi_cell
// One palette slot: compares the passing beat, claims the slot if free.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpi_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  ecpi_pkg::beat_t    beat_in,
    output ecpi_pkg::beat_t    beat_out,
    output logic               used
);
    import ecpi_pkg::*;

    logic               used_reg;
    logic               used_next;
    logic [COLOR_W-1:0] entry_reg;
    beat_t              beat_reg;
    beat_t              beat_next;
    logic               occupied;
    logic               hit;
    logic               claim;

    always_comb
    begin
        // start marker empties every slot it passes
        occupied  = used_reg && !beat_in.first;
        hit       = beat_in.valid && !beat_in.found && occupied
                    && (entry_reg == beat_in.color);
        claim     = beat_in.valid && !beat_in.found && !occupied;
        beat_next = beat_in;
        if (hit || claim)
        begin
            beat_next.found = 1'b1;
            beat_next.idx   = IDX_W'(CELL_INDEX);
        end
        if (claim)
        begin
            beat_next.is_new = 1'b1;
        end
        used_next = beat_in.valid ? (occupied || claim) : used_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            beat_reg <= '0;
        end
        else if (advance)
        begin
            used_reg <= used_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && claim)
        begin
            entry_reg <= beat_in.color;
        end
    end

    assign beat_out = beat_reg;
    assign used     = used_reg;

endmodule

`default_nettype wire

>>> src/ecpi_tail.sv
// ----------------------------------------------------------------------------
// ecpi_tail
// Output register: sticky overflow and forcing of overflowed results.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpi_tail (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  ecpi_pkg::beat_t beat_in,
    ecpi_result_if.source   result
);
    import ecpi_pkg::*;

    logic             valid_reg;
    logic             ovf_reg;
    logic             ovf_next;
    logic [IDX_W-1:0] idx_reg;
    logic             new_reg;

    // unfound at the end of the chain means the palette was full
    assign ovf_next = (ovf_reg && !beat_in.first) || !beat_in.found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= beat_in.valid;
            if (beat_in.valid)
            begin
                ovf_reg <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && beat_in.valid)
        begin
            idx_reg <= ovf_next ? '0 : beat_in.idx;
            new_reg <= beat_in.is_new && !ovf_next;
        end
    end

    assign result.valid        = valid_reg;
    assign result.color_index  = idx_reg;
    assign result.is_new_entry = new_reg;
    assign result.overflowed   = ovf_reg;

endmodule

`default_nettype wire

>>> src/exact_color_palette_indexer_unit.sv
// ----------------------------------------------------------------------------
// exact_color_palette_indexer_unit
// Exact-match palette indexer built as a systolic chain of palette cells.
// ----------------------------------------------------------------------------
// Each pixel beat passes the register of every cell, then the output register.
// Throughput: one pixel per cycle; each beat moves one cell per cycle.
// The whole chain holds while the output register is full and not taken.
// Reset clears beat valids, slot occupancy and overflow; no clearing pass.
`default_nettype none

module exact_color_palette_indexer_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ecpi_pixel_if.sink    pixel,
    ecpi_result_if.source result
);
    import ecpi_pkg::*;

    beat_t                      chain [PALETTE_ENTRIES+1];
    logic [PALETTE_ENTRIES-1:0] used_vec;
    logic                       advance;

    assign advance     = !result.valid || result.ready;
    assign pixel.ready = advance;

    always_comb
    begin
        chain[0].valid  = pixel.valid;
        chain[0].first  = pixel.first_pixel;
        chain[0].color  = {pixel.channel_3, pixel.channel_2,
                           pixel.channel_1, pixel.channel_0};
        chain[0].found  = 1'b0;
        chain[0].idx    = '0;
        chain[0].is_new = 1'b0;
    end

    for (genvar k = 0; k < PALETTE_ENTRIES; k++)
    begin : g_cell
        ecpi_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .beat_in  (chain[k]),
            .beat_out (chain[k+1]),
            .used     (used_vec[k])
        );
    end

    ecpi_tail u_tail (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .beat_in (chain[PALETTE_ENTRIES]),
        .result  (result)
    );

    // a stalled result beat is held
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid
            && $stable(result.color_index) && $stable(result.is_new_entry)
            && $stable(result.overflowed)))
        else $error("stalled result beat changed");

    a_accept_fills_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> used_vec[0])
        else $error("accepted pixel left slot zero empty");

    a_new_not_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.is_new_entry && result.overflowed))
        else $error("new entry flagged on overflowed image");

    a_ovf_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.overflowed) |-> (result.color_index == '0))
        else $error("overflowed result with non-zero index");

endmodule

`default_nettype wire
